### design/binary_keying_modulator_core_macros.svh
// ----------------------------------------------------------------------------
// Binary keying modulator assertion macros
// Shared assertion shorthands; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef BINARY_KEYING_MODULATOR_CORE_MACROS_SVH
`define BINARY_KEYING_MODULATOR_CORE_MACROS_SVH

// Consequent must hold on the cycle after the antecedent.
`define BKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BKM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/bkm_pkg.sv
// ----------------------------------------------------------------------------
// Binary keying modulator package
// Shared types, register codes, reset values and the sine table builder.
// ----------------------------------------------------------------------------
package bkm_pkg;

  localparam int MAX_SAMPLES_PER_BIT_DEF = 64;
  localparam int SINE_TABLE_BITS_DEF     = 10;
  localparam int PHASE_BITS_DEF          = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int AMP_W       = 8;
  localparam int INC_W       = 32;
  localparam int OFFS_W      = 16;
  localparam int SPB_W       = 7;
  localparam int SAMPLE_W    = 17;
  localparam int WAVE_W      = 16;
  localparam int QWAVE_W     = 15;

  localparam logic [AMP_W-1:0] AMP_ONE_RST  = 8'd64;
  localparam logic [AMP_W-1:0] AMP_ZERO_RST = 8'd128;
  localparam logic [SPB_W-1:0] SPB_RST      = 7'd16;

  // pi in unsigned Q40
  localparam longint unsigned PI_Q40 = 64'h0000_0324_3F6A_8886;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_AMP_ONE         = 3'd0,
    REG_AMP_ZERO        = 3'd1,
    REG_INC_ONE         = 3'd2,
    REG_INC_ZERO        = 3'd3,
    REG_PHASE_ONE       = 3'd4,
    REG_PHASE_ZERO      = 3'd5,
    REG_SAMPLES_PER_BIT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [AMP_W-1:0]  amp_one;
    logic [AMP_W-1:0]  amp_zero;
    logic [INC_W-1:0]  inc_one;
    logic [INC_W-1:0]  inc_zero;
    logic [OFFS_W-1:0] phase_one;
    logic [OFFS_W-1:0] phase_zero;
    logic [SPB_W-1:0]  samples_per_bit;
  } cfg_t;

  // Per-sample control that travels alongside the sine lookup.
  typedef struct packed {
    logic             data_level;
    logic             last;
    logic [AMP_W-1:0] amp;
  } smp_ctl_t;

  // Quarter-wave point k, unsigned Q0.15, from a 13-term Taylor series in Q28.
  function automatic logic [QWAVE_W-1:0] quarter_value(input int k, input int table_bits);
    longint unsigned prod;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    int              sh;
    sh   = table_bits + 12;
    prod = PI_Q40 * longint'(2 * k + 1);
    x    = (prod + (64'd1 << (sh - 1))) >> sh;
    x2   = (x * x) >> 28;
    term = x;
    sum  = longint'(x);
    term = (term * x2) >> 28; term = term / 64'd6;   sum = sum - longint'(term);
    term = (term * x2) >> 28; term = term / 64'd20;  sum = sum + longint'(term);
    term = (term * x2) >> 28; term = term / 64'd42;  sum = sum - longint'(term);
    term = (term * x2) >> 28; term = term / 64'd72;  sum = sum + longint'(term);
    term = (term * x2) >> 28; term = term / 64'd110; sum = sum - longint'(term);
    term = (term * x2) >> 28; term = term / 64'd156; sum = sum + longint'(term);
    term = (term * x2) >> 28; term = term / 64'd210; sum = sum - longint'(term);
    term = (term * x2) >> 28; term = term / 64'd272; sum = sum + longint'(term);
    term = (term * x2) >> 28; term = term / 64'd342; sum = sum - longint'(term);
    term = (term * x2) >> 28; term = term / 64'd420; sum = sum + longint'(term);
    term = (term * x2) >> 28; term = term / 64'd506; sum = sum - longint'(term);
    term = (term * x2) >> 28; term = term / 64'd600; sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * 64'd32767 + (64'd1 << 27)) >> 28;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[QWAVE_W-1:0];
  endfunction

endpackage

### design/binary_keying_modulator_core.sv
// ----------------------------------------------------------------------------
// Binary keying modulator core
// ASK / FSK / PSK carrier generator driven by one data bit per request.
// ----------------------------------------------------------------------------
// Each accepted request carries one data bit and produces samples_per_bit
// carrier samples (clamped to 1..MAX_SAMPLES_PER_BIT, zero counts as one),
// one sample per clock while the master side takes them. The next bit is
// taken in the same cycle as the last sample of the current one, so a bit
// stream runs with no gaps. An accepted bit is registered in the phase
// generator and each of its samples in the output stage. Each sample is
// amp * sin(phase + offset) with amplitude, increment and offset picked by
// the bit, so ASK, FSK and PSK are all just register settings. Two phase
// accumulators (one per increment) advance on every sample regardless of
// the bit; start_of_message zeroes both before its bit. The user must write
// configuration only while the core is idle; the core does not enforce it.
// ----------------------------------------------------------------------------
module binary_keying_modulator_core #(
  parameter int MAX_SAMPLES_PER_BIT = bkm_pkg::MAX_SAMPLES_PER_BIT_DEF,
  parameter int SINE_TABLE_BITS     = bkm_pkg::SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS          = bkm_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [bkm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bkm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // slave side: one data bit per request
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [0] data_bit, [7:1] zero
  input  logic                            s_tuser,   // [0] start_of_message
  // master side: one carrier sample per request
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // [16:0] sample, [23:17] zero
  output logic                            m_tuser,   // [0] data_level
  output logic                            m_tlast    // last_of_bit
);

  bkm_pkg::cfg_t                      cfg;
  bkm_pkg::smp_ctl_t                  smp_ctl;
  logic                               smp_valid;
  logic                               out_ready;
  logic [SINE_TABLE_BITS-1:0]         lut_addr;
  logic signed [bkm_pkg::WAVE_W-1:0]  wave;
  logic [bkm_pkg::SAMPLE_W-1:0]       sample;

  bkm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Holds the current bit, counts its samples, and runs the accumulators.
  bkm_phase_gen #(
    .MAX_SAMPLES_PER_BIT (MAX_SAMPLES_PER_BIT),
    .SINE_TABLE_BITS     (SINE_TABLE_BITS),
    .PHASE_BITS          (PHASE_BITS)
  ) u_phase (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .data_bit         (s_tdata[0]),
    .start_of_message (s_tuser),
    .out_ready        (out_ready),
    .smp_valid        (smp_valid),
    .smp_ctl          (smp_ctl),
    .lut_addr         (lut_addr)
  );

  // Quarter-wave sine table, addressed by the top phase bits.
  bkm_sine_lut #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_lut (
    .addr (lut_addr),
    .wave (wave)
  );

  // Amplitude scaling and the output register; advance only when it frees.
  bkm_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .smp_valid   (smp_valid),
    .smp_ctl     (smp_ctl),
    .wave        (wave),
    .out_ready   (out_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .sample      (sample),
    .data_level  (m_tuser),
    .last_of_bit (m_tlast)
  );

  assign m_tdata = {7'b0, sample};

endmodule

### design/bkm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Binary keying modulator configuration registers
// Write-only register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bkm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bkm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bkm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bkm_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amp_one         <= bkm_pkg::AMP_ONE_RST;
      cfg.amp_zero        <= bkm_pkg::AMP_ZERO_RST;
      cfg.inc_one         <= '0;
      cfg.inc_zero        <= '0;
      cfg.phase_one       <= '0;
      cfg.phase_zero      <= '0;
      cfg.samples_per_bit <= bkm_pkg::SPB_RST;
    end else if (cfg_we) begin
      case (bkm_pkg::cfg_reg_t'(cfg_index))
        bkm_pkg::REG_AMP_ONE:         cfg.amp_one         <= cfg_data[bkm_pkg::AMP_W-1:0];
        bkm_pkg::REG_AMP_ZERO:        cfg.amp_zero        <= cfg_data[bkm_pkg::AMP_W-1:0];
        bkm_pkg::REG_INC_ONE:         cfg.inc_one         <= cfg_data[bkm_pkg::INC_W-1:0];
        bkm_pkg::REG_INC_ZERO:        cfg.inc_zero        <= cfg_data[bkm_pkg::INC_W-1:0];
        bkm_pkg::REG_PHASE_ONE:       cfg.phase_one       <= cfg_data[bkm_pkg::OFFS_W-1:0];
        bkm_pkg::REG_PHASE_ZERO:      cfg.phase_zero      <= cfg_data[bkm_pkg::OFFS_W-1:0];
        bkm_pkg::REG_SAMPLES_PER_BIT: cfg.samples_per_bit <= cfg_data[bkm_pkg::SPB_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### design/bkm_phase_gen.sv
// ----------------------------------------------------------------------------
// Binary keying modulator phase generator
// Holds the current bit, counts its samples and runs both phase accumulators.
// ----------------------------------------------------------------------------
`include "binary_keying_modulator_core_macros.svh"

module bkm_phase_gen #(
  parameter int MAX_SAMPLES_PER_BIT = bkm_pkg::MAX_SAMPLES_PER_BIT_DEF,
  parameter int SINE_TABLE_BITS     = bkm_pkg::SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS          = bkm_pkg::PHASE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bkm_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       data_bit,
  input  logic                       start_of_message,
  input  logic                       out_ready,
  output logic                       smp_valid,
  output bkm_pkg::smp_ctl_t          smp_ctl,
  output logic [SINE_TABLE_BITS-1:0] lut_addr
);

  localparam int CW = (MAX_SAMPLES_PER_BIT > 1) ? $clog2(MAX_SAMPLES_PER_BIT) : 1;

  logic                  active;
  logic                  bit_q;
  logic [CW-1:0]         remaining;
  logic [PHASE_BITS-1:0] acc_one;
  logic [PHASE_BITS-1:0] acc_zero;

  logic                       accept;
  logic                       advance;
  logic                       final_smp;
  logic [bkm_pkg::SPB_W-1:0]  count_sat;
  logic [bkm_pkg::SPB_W-1:0]  count_m1;
  logic [PHASE_BITS-1:0]      inc_one_k;
  logic [PHASE_BITS-1:0]      inc_zero_k;
  logic [PHASE_BITS-1:0]      offs_ext;
  logic [PHASE_BITS-1:0]      lookup;

  // Clamp the sample count to 1..MAX.
  always_comb begin
    if (cfg.samples_per_bit == '0) begin
      count_sat = bkm_pkg::SPB_W'(1);
    end else if (cfg.samples_per_bit > bkm_pkg::SPB_W'(MAX_SAMPLES_PER_BIT)) begin
      count_sat = bkm_pkg::SPB_W'(MAX_SAMPLES_PER_BIT);
    end else begin
      count_sat = cfg.samples_per_bit;
    end
    count_m1 = count_sat - bkm_pkg::SPB_W'(1);
  end

  assign advance   = active && out_ready;
  assign final_smp = (remaining == '0);
  assign in_ready  = !active || (advance && final_smp);
  assign accept    = in_valid && in_ready;

  assign inc_one_k  = cfg.inc_one[bkm_pkg::INC_W-1 -: PHASE_BITS];
  assign inc_zero_k = cfg.inc_zero[bkm_pkg::INC_W-1 -: PHASE_BITS];

  always_comb begin
    offs_ext = PHASE_BITS'(bit_q ? cfg.phase_one : cfg.phase_zero) << (PHASE_BITS - 16);
    lookup   = (bit_q ? acc_one : acc_zero) + offs_ext;
  end

  assign lut_addr           = lookup[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign smp_valid          = advance;
  assign smp_ctl.data_level = bit_q;
  assign smp_ctl.last       = final_smp;
  assign smp_ctl.amp        = bit_q ? cfg.amp_one : cfg.amp_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      bit_q     <= 1'b0;
      remaining <= '0;
    end else if (accept) begin
      active    <= 1'b1;
      bit_q     <= data_bit;
      remaining <= count_m1[CW-1:0];
    end else if (advance && final_smp) begin
      active <= 1'b0;
    end else if (advance) begin
      remaining <= remaining - CW'(1);
    end
  end

  // Both accumulators run on every sample; a message start zeroes them.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_one  <= '0;
      acc_zero <= '0;
    end else if (accept && start_of_message) begin
      acc_one  <= '0;
      acc_zero <= '0;
    end else if (advance) begin
      acc_one  <= acc_one + inc_one_k;
      acc_zero <= acc_zero + inc_zero_k;
    end
  end

  `BKM_ASSERT_NEXT(a_som_clears, accept && start_of_message, acc_one == '0 && acc_zero == '0, "message start did not clear accumulators")
  `BKM_ASSERT_NEXT(a_acc_hold, !advance && !accept, $stable(acc_one) && $stable(acc_zero), "accumulators moved without a sample")
  `BKM_ASSERT_NEXT(a_cnt_hold, active && !out_ready, active && $stable(remaining) && $stable(bit_q), "sample counter moved while stalled")

endmodule

### design/bkm_sine_lut.sv
// ----------------------------------------------------------------------------
// Binary keying modulator sine lookup
// Quarter-wave constant table, mirrored and negated by the top phase bits.
// ----------------------------------------------------------------------------
module bkm_sine_lut #(
  parameter int SINE_TABLE_BITS = bkm_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic [SINE_TABLE_BITS-1:0]       addr,
  output logic signed [bkm_pkg::WAVE_W-1:0] wave
);

  localparam int QUARTER_LEN = 2 ** (SINE_TABLE_BITS - 2);

  logic [bkm_pkg::QWAVE_W-1:0] quarter_rom [QUARTER_LEN];
  logic [1:0]                  quad;
  logic [SINE_TABLE_BITS-3:0]  idx;
  logic [bkm_pkg::WAVE_W-1:0]  mag;

  for (genvar k = 0; k < QUARTER_LEN; k++) begin : g_rom
    localparam logic [bkm_pkg::QWAVE_W-1:0] QV = bkm_pkg::quarter_value(k, SINE_TABLE_BITS);
    assign quarter_rom[k] = QV;
  end

  always_comb begin
    quad = addr[SINE_TABLE_BITS-1 -: 2];
    idx  = quad[0] ? ~addr[SINE_TABLE_BITS-3:0] : addr[SINE_TABLE_BITS-3:0];
    mag  = {1'b0, quarter_rom[idx]};
    wave = quad[1] ? $signed(-mag) : $signed(mag);
  end

endmodule

### design/bkm_out_stage.sv
// ----------------------------------------------------------------------------
// Binary keying modulator output stage
// Scales the sine by the amplitude and holds the result for the master side.
// ----------------------------------------------------------------------------
module bkm_out_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                smp_valid,
  input  bkm_pkg::smp_ctl_t                   smp_ctl,
  input  logic signed [bkm_pkg::WAVE_W-1:0]   wave,
  output logic                                out_ready,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bkm_pkg::SAMPLE_W-1:0]        sample,
  output logic                                data_level,
  output logic                                last_of_bit
);

  localparam int PROD_W = bkm_pkg::WAVE_W + bkm_pkg::AMP_W + 1;

  logic signed [PROD_W-1:0] prod;

  // Signed sine times unsigned amplitude; taking bits from 7 up floors by 128.
  always_comb begin
    prod = $signed({{(PROD_W - bkm_pkg::WAVE_W){wave[bkm_pkg::WAVE_W-1]}}, wave}) *
           $signed({{(PROD_W - bkm_pkg::AMP_W){1'b0}}, smp_ctl.amp});
  end

  assign out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (smp_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_valid) begin
      sample      <= prod[bkm_pkg::SAMPLE_W+6:7];
      data_level  <= smp_ctl.data_level;
      last_of_bit <= smp_ctl.last;
    end
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Binary keying modulator core testbench
// Sends data bit requests under random flow control and checks every carrier
// sample against a sample-accurate predictor of the ASK / FSK / PSK core.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bkm_pkg::*;

  // Sine lookup geometry and the index that no register answers to.
  localparam int TOP_W       = SINE_TABLE_BITS_DEF;
  localparam int QIDX_W      = SINE_TABLE_BITS_DEF - 2;
  localparam int QUARTER_LEN = 1 << QIDX_W;
  localparam int ANGLE_SHIFT = SINE_TABLE_BITS_DEF + 12;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       level;
    logic                       closes_bit;
  } carrier_sample_t;

  // Predicts the carrier samples of each accepted bit and checks them in order.
  class carrier_scoreboard;
    logic [AMP_W-1:0]   amp_one, amp_zero;
    logic [INC_W-1:0]   inc_one, inc_zero;
    logic [OFFS_W-1:0]  offs_one, offs_zero;
    logic [SPB_W-1:0]   spb;
    logic [31:0]        acc_one, acc_zero;
    logic [QWAVE_W-1:0] quarter [QUARTER_LEN];
    carrier_sample_t    expected_q [$];
    int                 mismatches;

    function new();
      longint unsigned mult, x, s, v;
      for (int k = 0; k < QUARTER_LEN; k++) begin
        mult = 2 * k + 1;
        x = (PI_Q40 * mult + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT;
        s = taylor_sine(x);
        v = (s * 32767 + (64'd1 << 27)) >> 28;
        if (v > 32767) v = 32767;
        quarter[k] = v[QWAVE_W-1:0];
      end
      amp_one    = AMP_ONE_RST;
      amp_zero   = AMP_ZERO_RST;
      inc_one    = '0;
      inc_zero   = '0;
      offs_one   = '0;
      offs_zero  = '0;
      spb        = SPB_RST;
      acc_one    = '0;
      acc_zero   = '0;
      mismatches = 0;
    endfunction

    // sin(x) for x in (0, pi/2), argument and result in unsigned Q28
    function longint unsigned taylor_sine(longint unsigned x);
      longint unsigned x2, term;
      longint          acc;
      x2   = (x * x) >> 28;
      term = x;
      acc  = x;
      for (int n = 1; n <= 12; n++) begin
        term = (term * x2) >> 28;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      return acc;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_AMP_ONE:         amp_one   = value[AMP_W-1:0];
        REG_AMP_ZERO:        amp_zero  = value[AMP_W-1:0];
        REG_INC_ONE:         inc_one   = value[INC_W-1:0];
        REG_INC_ZERO:        inc_zero  = value[INC_W-1:0];
        REG_PHASE_ONE:       offs_one  = value[OFFS_W-1:0];
        REG_PHASE_ZERO:      offs_zero = value[OFFS_W-1:0];
        REG_SAMPLES_PER_BIT: spb       = value[SPB_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_bit(logic data_bit, logic som);
      int               count;
      int               wave;
      int               product;
      logic [31:0]      phase;
      logic [TOP_W-1:0] top;
      logic [QIDX_W-1:0] idx;
      logic [AMP_W-1:0] amp;
      logic [OFFS_W-1:0] offs;
      carrier_sample_t  s;
      count = (spb == 0) ? 1 : ((spb > MAX_SAMPLES_PER_BIT_DEF) ? MAX_SAMPLES_PER_BIT_DEF
                                                                 : int'(spb));
      if (som) begin
        acc_one  = '0;
        acc_zero = '0;
      end
      amp  = data_bit ? amp_one : amp_zero;
      offs = data_bit ? offs_one : offs_zero;
      for (int n = 0; n < count; n++) begin
        phase = (data_bit ? acc_one : acc_zero) + {offs, 16'd0};
        top   = phase[31 -: TOP_W];
        idx   = top[QIDX_W-1:0];
        // odd quadrants run the quarter wave backward, the lower half negates
        if (top[TOP_W-2]) idx = ~idx;
        wave = int'(quarter[idx]);
        if (top[TOP_W-1]) wave = -wave;
        product = wave * int'(amp);
        s.sample     = SAMPLE_W'(product >>> 7);
        s.level      = data_bit;
        s.closes_bit = (n == count - 1);
        expected_q.push_back(s);
        acc_one  = acc_one + inc_one;
        acc_zero = acc_zero + inc_zero;
      end
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] sample, logic level,
                               logic closes_bit);
      carrier_sample_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected sample %0d level %0b last %0b", $time, sample, level,
                   closes_bit);
        return;
      end
      e = expected_q.pop_front();
      if (e.sample !== sample || e.level !== level || e.closes_bit !== closes_bit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch, expected %0d level %0b last %0b, got %0d %0b %0b",
                   $time, e.sample, e.level, e.closes_bit, sample, level, closes_bit);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic [7:0]             s_tdata   = '0;   // [0] data_bit, [7:1] zero
  logic                   s_tuser   = 1'b0; // [0] start_of_message
  logic                   m_tready  = 1'b0;
  logic                   hold_go   = 1'b0;
  logic                   hold_off  = 1'b0;
  wire                    s_tready;
  wire                    m_tvalid;
  wire  [23:0]            m_tdata;          // [16:0] sample, [23:17] zero
  wire                    m_tuser;          // [0] data_level
  wire                    m_tlast;          // last_of_bit

  int send_gap_pct = 23;
  int recv_gap_pct = 51;

  carrier_scoreboard board = new();

  binary_keying_modulator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random, or hold off completely while a long stall runs.
  always @(posedge clk) begin
    if (hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Long receiver stall, counted here so the sender keeps offering meanwhile.
  initial begin : receiver_hold_off
    do @(posedge clk); while (!hold_go);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Check every sample the master side hands over.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_sample(m_tdata[SAMPLE_W-1:0], m_tuser, m_tlast);
    end
  end

  // Offer one data bit request, idling first at random; predict on acceptance.
  task automatic send_bit(input logic data_bit, input logic som);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, data_bit};
    s_tuser  <= som;
    do @(posedge clk); while (!s_tready);
    board.note_bit(data_bit, som);
  endtask

  // Write one register; lower the enable on the following cycle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    board.write_reg(index, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering and wait for every predicted sample, then let the core settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Full random register set; upper data bits are left random to exercise masking.
  task automatic random_settings(input int max_spb);
    write_reg(REG_AMP_ONE, $urandom);
    write_reg(REG_AMP_ZERO, $urandom);
    write_reg(REG_INC_ONE, $urandom);
    write_reg(REG_INC_ZERO, $urandom);
    write_reg(REG_PHASE_ONE, $urandom);
    write_reg(REG_PHASE_ZERO, $urandom);
    write_reg(REG_SAMPLES_PER_BIT, $urandom_range(max_spb, 1));
  endtask

  // Mostly whole messages that open with a start flag, some loose bits as noise.
  task automatic random_traffic(input int items);
    int done;
    int len;
    done = 0;
    while (done < items) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) send_bit(1'($urandom_range(1)), i == 0);
        done += len;
      end else begin
        send_bit(1'($urandom_range(1)), 1'($urandom_range(1)));
        done++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 16 samples per bit, no increment, both amplitudes.
    send_bit(1'b0, 1'b1);
    send_bit(1'b1, 1'b0);
    drain();

    // Extremes: full and zero amplitude, largest increment, zero samples per bit
    // (counts as one), offsets masked to 16 bits, an index with no register.
    write_reg(REG_AMP_ONE, 32'hFFFF_FFFF);
    write_reg(REG_AMP_ZERO, 32'h0000_0000);
    write_reg(REG_INC_ONE, 32'hFFFF_FFFF);
    write_reg(REG_INC_ZERO, 32'h0040_0000);
    write_reg(REG_PHASE_ONE, 32'h0000_FFFF);
    write_reg(REG_PHASE_ZERO, 32'hFFFF_4000);
    write_reg(REG_SAMPLES_PER_BIT, 32'd0);
    write_reg(REG_UNUSED, 32'h0000_0001);
    send_bit(1'b1, 1'b1);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);
    drain();

    // Oversized count saturates to the maximum; sweep a full turn per bit.
    write_reg(REG_SAMPLES_PER_BIT, 32'h0000_007F);
    write_reg(REG_INC_ONE, 32'h0400_0000);
    write_reg(REG_INC_ZERO, 32'h0400_0000);
    write_reg(REG_AMP_ZERO, 32'd1);
    write_reg(REG_PHASE_ONE, 32'd0);
    write_reg(REG_PHASE_ZERO, 32'd0);
    send_bit(1'b1, 1'b1);
    send_bit(1'b0, 1'b0);
    drain();

    // PSK: equal amplitude, half-turn offset on ones, exactly the maximum count.
    write_reg(REG_SAMPLES_PER_BIT, 32'd64);
    write_reg(REG_AMP_ZERO, 32'd255);
    write_reg(REG_PHASE_ONE, 32'h0000_8000);
    send_bit(1'b0, 1'b1);
    send_bit(1'b1, 1'b0);
    drain();
    write_reg(REG_SAMPLES_PER_BIT, 32'd65);
    send_bit(1'b1, 1'b0);
    drain();

    // FSK with one sample per bit; the zero tone steps half a turn each sample.
    write_reg(REG_SAMPLES_PER_BIT, 32'd1);
    write_reg(REG_AMP_ONE, 32'hABCD_EF80);
    write_reg(REG_INC_ONE, 32'h1234_5678);
    write_reg(REG_INC_ZERO, 32'h8000_0000);
    write_reg(REG_PHASE_ONE, 32'd0);
    for (int i = 0; i < 8; i++) send_bit(i[0], i == 0 || i == 5);
    drain();

    // Random traffic, sender idling 23 percent of the time and receiver 51 percent.
    random_settings(8);
    random_traffic(50);
    drain();

    // Swap the idle rates; include the longest bits.
    send_gap_pct = 51;
    recv_gap_pct = 23;
    random_settings(16);
    random_traffic(25);
    drain();
    random_settings(64);
    random_traffic(15);
    drain();

    // No idling; hold the receiver off so the core backs up into the sender.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_settings(4);
    hold_go <= 1'b1;
    random_traffic(50);
    drain();

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
